FILE: sv/pff_pkg.sv
// pareto front filter package: sizes, payload structs, register and state codes
// dominance and priority helpers used by the front and back ends
// no dependencies
package pff_pkg;

  localparam int FRONT_DEPTH  = 32;
  localparam int METRIC_WIDTH = 32;
  localparam int FIELD_W      = 32;
  localparam int SIZE_W       = 6;
  localparam int IDX_W        = $clog2(FRONT_DEPTH);
  localparam int CNT_W        = $clog2(FRONT_DEPTH + 1);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int NUM_REGS     = 4;
  localparam int REG_IDX_W    = $clog2(NUM_REGS);
  localparam int ADDR_W       = REG_IDX_W + 2;
  localparam int DATA_W       = 32;

  typedef logic [METRIC_WIDTH-1:0] metric_t;

  typedef struct packed {
    metric_t compute;
    metric_t capacity;
    metric_t memory_bw;
    metric_t link_bw;
  } point_t;

  typedef struct packed {
    logic [FIELD_W-1:0] compute_metric;
    logic [FIELD_W-1:0] capacity_metric;
    logic [FIELD_W-1:0] memory_bw_metric;
    logic [FIELD_W-1:0] link_bw_metric;
    logic               batch_end;
  } cand_t;

  typedef struct packed {
    logic [FIELD_W-1:0] out_compute;
    logic [FIELD_W-1:0] out_capacity;
    logic [FIELD_W-1:0] out_memory_bw;
    logic [FIELD_W-1:0] out_link_bw;
    logic               entry_present;
    logic               final_entry;
    logic               overflowed;
    logic [SIZE_W-1:0]  front_size;
  } result_t;

  // one queued request: point, batch marker, and whether it passed the thresholds
  typedef struct packed {
    point_t point;
    logic   batch_end;
    logic   keep;
  } work_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MIN_COMPUTE,
    REG_MIN_CAPACITY,
    REG_MIN_MEMORY_BW,
    REG_MIN_LINK_BW
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD,
    ST_COUNT,
    ST_DUMP
  } back_state_t;

  function automatic metric_t to_metric(logic [FIELD_W-1:0] x);
    return metric_t'(x);
  endfunction

  // a weakly dominates b
  function automatic logic covers(point_t a, point_t b);
    return (a.compute >= b.compute) && (a.capacity >= b.capacity) &&
           (a.memory_bw >= b.memory_bw) && (a.link_bw >= b.link_bw);
  endfunction

  // index of the lowest set bit, zero when none
  function automatic logic [IDX_W-1:0] first_set(logic [FRONT_DEPTH-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = FRONT_DEPTH - 1; i >= 0; i--) begin
      if (v[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

FILE: sv/pff_front.sv
// pareto front filter front end: takes candidates and checks the thresholds
// depends on pff_pkg
module pff_front (
  input  logic            cand_valid,
  output logic            cand_ready,
  input  pff_pkg::cand_t  cand,
  input  pff_pkg::point_t thr,
  output logic            push_valid,
  input  logic            push_ready,
  output pff_pkg::work_t  push_item
);

  pff_pkg::point_t pt;
  logic            pass;

  assign pt.compute   = pff_pkg::to_metric(cand.compute_metric);
  assign pt.capacity  = pff_pkg::to_metric(cand.capacity_metric);
  assign pt.memory_bw = pff_pkg::to_metric(cand.memory_bw_metric);
  assign pt.link_bw   = pff_pkg::to_metric(cand.link_bw_metric);

  assign pass = pff_pkg::covers(pt, thr);

  // failing points vanish here unless they close a batch
  assign cand_ready          = push_ready;
  assign push_valid          = cand_valid && (pass || cand.batch_end);
  assign push_item.point     = pt;
  assign push_item.batch_end = cand.batch_end;
  assign push_item.keep      = pass;

endmodule

FILE: sv/pff_queue.sv
// pareto front filter request queue between front and back ends
// depends on pff_pkg
module pff_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  pff_pkg::work_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output pff_pkg::work_t pop_item
);

  pff_pkg::work_t                  slots [pff_pkg::QUEUE_DEPTH];
  logic [pff_pkg::QPTR_W-1:0]      wr_ptr;
  logic [pff_pkg::QPTR_W-1:0]      rd_ptr;
  logic [pff_pkg::QCNT_W-1:0]      fill;
  logic                            push;
  logic                            pop;

  assign push_ready = (fill != pff_pkg::QCNT_W'(pff_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  function automatic logic [pff_pkg::QPTR_W-1:0] bump(logic [pff_pkg::QPTR_W-1:0] p);
    return (p == pff_pkg::QPTR_W'(pff_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop) rd_ptr <= bump(rd_ptr);
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

FILE: sv/pff_back.sv
// pareto front filter back end: register-held front, dominance compare,
// slot update and front dump through an output register; depends on pff_pkg
module pff_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  pff_pkg::work_t   q_item,
  output logic             res_valid,
  input  logic             res_ready,
  output pff_pkg::result_t res
);

  pff_pkg::back_state_t              state;
  pff_pkg::back_state_t              state_next;
  pff_pkg::point_t                   store [pff_pkg::FRONT_DEPTH];
  logic [pff_pkg::FRONT_DEPTH-1:0]   slot_valid;
  logic                              overflow_seen;
  pff_pkg::work_t                    cur;
  logic [pff_pkg::FRONT_DEPTH-1:0]   evict;
  logic                              covered;
  logic [pff_pkg::FRONT_DEPTH-1:0]   pending;
  logic [pff_pkg::CNT_W-1:0]         count;
  logic [pff_pkg::CNT_W-1:0]         rem;

  logic [pff_pkg::FRONT_DEPTH-1:0]   evict_vec;
  logic [pff_pkg::FRONT_DEPTH-1:0]   covered_vec;
  logic [pff_pkg::FRONT_DEPTH-1:0]   valid_after;
  logic [pff_pkg::FRONT_DEPTH-1:0]   ins_mask;
  logic [pff_pkg::IDX_W-1:0]         free_idx;
  logic [pff_pkg::IDX_W-1:0]         emit_idx;
  logic                              has_free;
  logic                              want_insert;
  logic                              upd_write;
  logic                              upd_ovf;
  logic                              pop;
  logic                              ld;
  logic                              last_out;
  pff_pkg::point_t                   emit_pt;

  // comparators against every slot
  always_comb begin
    for (int s = 0; s < pff_pkg::FRONT_DEPTH; s++) begin
      evict_vec[s]   = slot_valid[s] && pff_pkg::covers(cur.point, store[s]);
      covered_vec[s] = slot_valid[s] && pff_pkg::covers(store[s], cur.point);
    end
  end

  assign valid_after = slot_valid & ~evict;
  assign want_insert = (evict != '0) || !covered;
  assign has_free    = (valid_after != {pff_pkg::FRONT_DEPTH{1'b1}});
  assign free_idx    = pff_pkg::first_set(~valid_after);
  assign emit_idx    = pff_pkg::first_set(pending);
  assign emit_pt     = store[emit_idx];
  assign last_out    = (count == '0) || (rem == pff_pkg::CNT_W'(1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pff_pkg::ST_IDLE: begin
        if (q_valid) state_next = q_item.keep ? pff_pkg::ST_CMP : pff_pkg::ST_COUNT;
      end
      pff_pkg::ST_CMP: state_next = pff_pkg::ST_UPD;
      pff_pkg::ST_UPD: state_next = cur.batch_end ? pff_pkg::ST_COUNT : pff_pkg::ST_IDLE;
      pff_pkg::ST_COUNT: state_next = pff_pkg::ST_DUMP;
      pff_pkg::ST_DUMP: begin
        if (ld && last_out) state_next = pff_pkg::ST_IDLE;
      end
      default: state_next = pff_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_ready   = 1'b0;
    upd_write = 1'b0;
    upd_ovf   = 1'b0;
    ld        = 1'b0;
    unique case (state)
      pff_pkg::ST_IDLE: q_ready = 1'b1;
      pff_pkg::ST_UPD: begin
        upd_write = want_insert && has_free;
        upd_ovf   = want_insert && !has_free;
      end
      pff_pkg::ST_DUMP: ld = !res_valid || res_ready;
      default: ;
    endcase
  end

  assign pop      = q_valid && q_ready;
  assign ins_mask = upd_write ? (pff_pkg::FRONT_DEPTH'(1) << free_idx) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pff_pkg::ST_IDLE;
      slot_valid    <= '0;
      overflow_seen <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (ld) res_valid <= 1'b1;
      else if (res_valid && res_ready) res_valid <= 1'b0;
      if (state == pff_pkg::ST_UPD) slot_valid <= valid_after | ins_mask;
      if (upd_ovf) overflow_seen <= 1'b1;
      if (ld && last_out) begin
        slot_valid    <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

  // payload and bookkeeping registers
  always_ff @(posedge clk) begin
    if (pop) cur <= q_item;
    if (state == pff_pkg::ST_CMP) begin
      evict   <= evict_vec;
      covered <= (covered_vec != '0);
    end
    if (upd_write) store[free_idx] <= cur.point;
    if (state == pff_pkg::ST_COUNT) begin
      count   <= pff_pkg::CNT_W'($countones(slot_valid));
      rem     <= pff_pkg::CNT_W'($countones(slot_valid));
      pending <= slot_valid;
    end
    if (ld) begin
      res.overflowed  <= overflow_seen;
      res.final_entry <= last_out;
      res.front_size  <= pff_pkg::SIZE_W'(count);
      if (count == '0) begin
        res.out_compute   <= '0;
        res.out_capacity  <= '0;
        res.out_memory_bw <= '0;
        res.out_link_bw   <= '0;
        res.entry_present <= 1'b0;
      end else begin
        res.out_compute   <= pff_pkg::FIELD_W'(emit_pt.compute);
        res.out_capacity  <= pff_pkg::FIELD_W'(emit_pt.capacity);
        res.out_memory_bw <= pff_pkg::FIELD_W'(emit_pt.memory_bw);
        res.out_link_bw   <= pff_pkg::FIELD_W'(emit_pt.link_bw);
        res.entry_present <= 1'b1;
        pending           <= pending & ~(pff_pkg::FRONT_DEPTH'(1) << emit_idx);
        rem               <= rem - 1'b1;
      end
    end
  end

  a_ovf_only_when_full: assert property (@(posedge clk) disable iff (rst)
    $rose(overflow_seen) |-> (&$past(slot_valid)))
    else $error("overflow flagged with a free slot");

  a_pending_matches_rem: assert property (@(posedge clk) disable iff (rst)
    (state == pff_pkg::ST_DUMP) |-> ($countones(pending) == rem))
    else $error("dump bookkeeping out of step");

  a_dump_clears_front: assert property (@(posedge clk) disable iff (rst)
    (ld && last_out) |=> (slot_valid == '0 && !overflow_seen && res_valid))
    else $error("front not cleared after final entry");

  a_no_pop_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != pff_pkg::ST_IDLE) |-> !q_ready)
    else $error("request taken while back end busy");

endmodule

FILE: sv/pareto_front_filter_top.sv
// pareto front filter top level: apb threshold registers, front end, queue, back end
// depends on pff_pkg, pff_front, pff_queue, pff_back
//
// Keeps a Pareto front of up to 32 four-metric candidate points under weak
// dominance. Each request on the cand channel is checked against the four
// threshold registers (byte addresses 0, 4, 8, 12 on the apb port); a point
// failing any threshold is dropped in the front end and costs no back-end time,
// unless it carries batch_end. A surviving point goes through a two-entry queue
// to the back end, which takes it from the queue while idle, runs the parallel
// compare against every stored slot, then applies evictions and writes the lowest
// free slot; it takes no new request until it is idle again, and the queue lets
// the cand channel keep taking requests while the back end is busy. After the
// batch_end request, a count state tallies the front, then one entry per cycle is
// loaded into the output register in ascending slot order, as fast as res_ready
// lets it drain; an empty front yields a single result with entry_present low.
// The final result carries final_entry, and the front and the sticky overflow
// flag are cleared when it is loaded. Threshold writes belong between batches.
module pareto_front_filter_top (
  input  logic                         clk,
  input  logic                         rst,
  // candidate requests
  input  logic                         cand_valid,
  output logic                         cand_ready,
  input  pff_pkg::cand_t               cand,
  // front entries
  output logic                         res_valid,
  input  logic                         res_ready,
  output pff_pkg::result_t             res,
  // apb configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pff_pkg::ADDR_W-1:0]   paddr,
  input  logic [pff_pkg::DATA_W-1:0]   pwdata,
  output logic [pff_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  logic [pff_pkg::DATA_W-1:0] min_compute;
  logic [pff_pkg::DATA_W-1:0] min_capacity;
  logic [pff_pkg::DATA_W-1:0] min_memory_bw;
  logic [pff_pkg::DATA_W-1:0] min_link_bw;
  pff_pkg::reg_idx_t          reg_sel;
  logic                       wr_en;
  pff_pkg::point_t            thr;

  logic                       push_valid;
  logic                       push_ready;
  pff_pkg::work_t             push_item;
  logic                       pop_valid;
  logic                       pop_ready;
  pff_pkg::work_t             pop_item;

  // no wait states
  assign pready  = 1'b1;
  assign reg_sel = pff_pkg::reg_idx_t'(paddr[pff_pkg::ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_compute   <= '0;
      min_capacity  <= '0;
      min_memory_bw <= '0;
      min_link_bw   <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        pff_pkg::REG_MIN_COMPUTE:   min_compute   <= pwdata;
        pff_pkg::REG_MIN_CAPACITY:  min_capacity  <= pwdata;
        pff_pkg::REG_MIN_MEMORY_BW: min_memory_bw <= pwdata;
        pff_pkg::REG_MIN_LINK_BW:   min_link_bw   <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_sel)
      pff_pkg::REG_MIN_COMPUTE:   prdata = min_compute;
      pff_pkg::REG_MIN_CAPACITY:  prdata = min_capacity;
      pff_pkg::REG_MIN_MEMORY_BW: prdata = min_memory_bw;
      pff_pkg::REG_MIN_LINK_BW:   prdata = min_link_bw;
      default:                    prdata = '0;
    endcase
  end

  // thresholds cast to the metric width
  assign thr.compute   = pff_pkg::to_metric(min_compute);
  assign thr.capacity  = pff_pkg::to_metric(min_capacity);
  assign thr.memory_bw = pff_pkg::to_metric(min_memory_bw);
  assign thr.link_bw   = pff_pkg::to_metric(min_link_bw);

  pff_front u_front (
    .cand_valid (cand_valid),
    .cand_ready (cand_ready),
    .cand       (cand),
    .thr        (thr),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  pff_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  pff_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_item    (pop_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

FILE: sim/tb.sv
// sim/tb.sv: self-checking testbench for the pareto front filter
// depends on pff_pkg (payload structs, register codes, sizes) and pareto_front_filter_top
// holds its own front model; results are checked in order as they leave the block
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 7;
  // back end takes one queued point at a time, queue holds two
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 300000;

  // ---------------------------------------------------------------------------
  // block ports, every input known from time zero
  // ---------------------------------------------------------------------------
  logic                         clk        = 1'b0;
  logic                         rst        = 1'b1;
  logic                         cand_valid = 1'b0;
  logic                         cand_ready;
  pff_pkg::cand_t               cand       = '0;
  logic                         res_valid;
  logic                         res_ready  = 1'b0;
  pff_pkg::result_t             res;
  logic                         psel       = 1'b0;
  logic                         penable    = 1'b0;
  logic                         pwrite     = 1'b0;
  logic [pff_pkg::ADDR_W-1:0]   paddr      = '0;
  logic [pff_pkg::DATA_W-1:0]   pwdata     = '0;
  logic [pff_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  pareto_front_filter_top dut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // front model: slots, live bits, sticky overflow, threshold copies
  // ---------------------------------------------------------------------------
  pff_pkg::point_t                 slot_pt [pff_pkg::FRONT_DEPTH];
  logic [pff_pkg::FRONT_DEPTH-1:0] live_slots = '0;
  logic                            overflow_q = 1'b0;
  pff_pkg::metric_t                floor_q [pff_pkg::NUM_REGS] = '{default: '0};
  pff_pkg::result_t                front_q [$];   // front entries still owed by the block
  pff_pkg::point_t                 recent_q [$];  // points of the current batch, for repeats

  // idling mix in percent
  int idle_pct  = 0;
  int stall_pct = 0;

  // run statistics
  int requests_sent   = 0;
  int entries_seen    = 0;
  int batches_done    = 0;
  int overflow_batches = 0;
  int floor_writes    = 0;
  int errors          = 0;
  int cycle_count     = 0;

  // weak dominance: a is at least as good as b in all four metrics
  function automatic bit dominates(pff_pkg::point_t a, pff_pkg::point_t b);
    return a.compute >= b.compute && a.capacity >= b.capacity &&
           a.memory_bw >= b.memory_bw && a.link_bw >= b.link_bw;
  endfunction

  // evict what p covers, else drop p if covered, then lowest free slot
  function automatic void admit_point(pff_pkg::point_t p);
    logic [pff_pkg::FRONT_DEPTH-1:0] beaten;
    beaten = '0;
    for (int s = 0; s < pff_pkg::FRONT_DEPTH; s++) begin
      if (live_slots[s] && dominates(p, slot_pt[s])) beaten[s] = 1'b1;
    end
    if (beaten != '0) begin
      live_slots &= ~beaten;
    end else begin
      for (int s = 0; s < pff_pkg::FRONT_DEPTH; s++) begin
        if (live_slots[s] && dominates(slot_pt[s], p)) return;
      end
    end
    for (int s = 0; s < pff_pkg::FRONT_DEPTH; s++) begin
      if (!live_slots[s]) begin
        slot_pt[s]    = p;
        live_slots[s] = 1'b1;
        return;
      end
    end
    // full and nothing evicted
    overflow_q = 1'b1;
  endfunction

  // apply one accepted request; on batch end queue the whole front
  function automatic void predict_front(pff_pkg::cand_t c);
    pff_pkg::point_t  p;
    pff_pkg::result_t r;
    int               n;
    int               k;
    p.compute   = pff_pkg::metric_t'(c.compute_metric);
    p.capacity  = pff_pkg::metric_t'(c.capacity_metric);
    p.memory_bw = pff_pkg::metric_t'(c.memory_bw_metric);
    p.link_bw   = pff_pkg::metric_t'(c.link_bw_metric);
    if (p.compute >= floor_q[pff_pkg::REG_MIN_COMPUTE] &&
        p.capacity >= floor_q[pff_pkg::REG_MIN_CAPACITY] &&
        p.memory_bw >= floor_q[pff_pkg::REG_MIN_MEMORY_BW] &&
        p.link_bw >= floor_q[pff_pkg::REG_MIN_LINK_BW]) admit_point(p);
    if (!c.batch_end) return;
    n = $countones(live_slots);
    batches_done++;
    if (overflow_q) overflow_batches++;
    if (n == 0) begin
      // empty front still answers with one marker entry
      r             = '0;
      r.final_entry = 1'b1;
      r.overflowed  = overflow_q;
      front_q       = {front_q, r};
    end else begin
      k = 0;
      for (int s = 0; s < pff_pkg::FRONT_DEPTH; s++) begin
        if (live_slots[s]) begin
          k++;
          r.out_compute   = slot_pt[s].compute;
          r.out_capacity  = slot_pt[s].capacity;
          r.out_memory_bw = slot_pt[s].memory_bw;
          r.out_link_bw   = slot_pt[s].link_bw;
          r.entry_present = 1'b1;
          r.final_entry   = (k == n);
          r.overflowed    = overflow_q;
          r.front_size    = pff_pkg::SIZE_W'(n);
          front_q         = {front_q, r};
        end
      end
    end
    live_slots = '0;
    overflow_q = 1'b0;
  endfunction

  function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    errors++;
    $display("%0t ns: %s expected %0h got %0h", $time, what, want, got);
  endfunction

  // compare one front entry with the oldest one owed
  task automatic check_entry(pff_pkg::result_t got);
    pff_pkg::result_t want;
    if (front_q.size() == 0) begin
      note_mismatch("front entry with none owed, entry", '0, 64'(got.out_compute));
      return;
    end
    want = front_q[0];
    front_q.delete(0);
    entries_seen++;
    if (want.out_compute !== got.out_compute)
      note_mismatch("out_compute", want.out_compute, got.out_compute);
    if (want.out_capacity !== got.out_capacity)
      note_mismatch("out_capacity", want.out_capacity, got.out_capacity);
    if (want.out_memory_bw !== got.out_memory_bw)
      note_mismatch("out_memory_bw", want.out_memory_bw, got.out_memory_bw);
    if (want.out_link_bw !== got.out_link_bw)
      note_mismatch("out_link_bw", want.out_link_bw, got.out_link_bw);
    if (want.entry_present !== got.entry_present)
      note_mismatch("entry_present", want.entry_present, got.entry_present);
    if (want.final_entry !== got.final_entry)
      note_mismatch("final_entry", want.final_entry, got.final_entry);
    if (want.overflowed !== got.overflowed)
      note_mismatch("overflowed", want.overflowed, got.overflowed);
    if (want.front_size !== got.front_size)
      note_mismatch("front_size", want.front_size, got.front_size);
  endtask

  // ---------------------------------------------------------------------------
  // monitor: values seen here are the ones present before the edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (cand_valid && cand_ready) predict_front(cand);
      if (res_valid && res_ready) check_entry(res);
    end
  end

  // receiver stalls at random per the current mix
  always @(posedge clk) begin
    res_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("watchdog hit after %0d cycles, %0d front entries still owed",
               cycle_count, front_q.size());
      $display("pareto_front_filter_top: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // request and register access
  // ---------------------------------------------------------------------------
  function automatic pff_pkg::cand_t make_cand(pff_pkg::metric_t a, pff_pkg::metric_t b,
                                               pff_pkg::metric_t c, pff_pkg::metric_t d,
                                               logic ends);
    pff_pkg::cand_t x;
    x.compute_metric   = a;
    x.capacity_metric  = b;
    x.memory_bw_metric = c;
    x.link_bw_metric   = d;
    x.batch_end        = ends;
    return x;
  endfunction

  // one request; valid stays up from a previous request unless an idle gap is drawn
  task automatic send_cand(pff_pkg::cand_t c);
    while ($urandom_range(99) < idle_pct) begin
      cand_valid <= 1'b0;
      @(posedge clk);
    end
    cand_valid <= 1'b1;
    cand       <= c;
    do @(posedge clk); while (!cand_ready);
    requests_sent++;
  endtask

  // block done with everything sent so far: all owed entries back, then settle
  task automatic wait_idle();
    cand_valid <= 1'b0;
    @(posedge clk);
    while (front_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(pff_pkg::reg_idx_t r, logic [pff_pkg::DATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= pff_pkg::ADDR_W'({r, 2'b00});
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    floor_q[r] = pff_pkg::metric_t'(v);
    floor_writes++;
  endtask

  // read back one threshold and compare with the model copy
  task automatic verify_floor(pff_pkg::reg_idx_t r);
    logic [pff_pkg::DATA_W-1:0] v;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= pff_pkg::ADDR_W'({r, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    v = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (v !== pff_pkg::DATA_W'(floor_q[r])) note_mismatch(r.name(), floor_q[r], v);
  endtask

  task automatic set_floors(pff_pkg::metric_t a, pff_pkg::metric_t b,
                            pff_pkg::metric_t c, pff_pkg::metric_t d);
    apb_write(pff_pkg::REG_MIN_COMPUTE, a);
    apb_write(pff_pkg::REG_MIN_CAPACITY, b);
    apb_write(pff_pkg::REG_MIN_MEMORY_BW, c);
    apb_write(pff_pkg::REG_MIN_LINK_BW, d);
    for (int i = 0; i < pff_pkg::NUM_REGS; i++) verify_floor(pff_pkg::reg_idx_t'(i));
  endtask

  // ---------------------------------------------------------------------------
  // random point source
  // ---------------------------------------------------------------------------
  function automatic pff_pkg::metric_t rand_floor();
    return ($urandom_range(9) < 7) ? pff_pkg::metric_t'($urandom_range(3)) :
                                     pff_pkg::metric_t'($urandom);
  endfunction

  // mix of tight clusters (lots of dominance and ties), full-range noise,
  // trade-off curves that grow the front, and exact repeats
  function automatic pff_pkg::cand_t random_cand(pff_pkg::metric_t base, logic ends);
    pff_pkg::point_t p;
    int              mode;
    int              t;
    mode = $urandom_range(99);
    if (mode >= 85 && recent_q.size() != 0) begin
      p = recent_q[$urandom_range(recent_q.size() - 1)];
    end else if (mode < 45) begin
      p.compute   = base + pff_pkg::metric_t'($urandom_range(7));
      p.capacity  = base + pff_pkg::metric_t'($urandom_range(7));
      p.memory_bw = base + pff_pkg::metric_t'($urandom_range(7));
      p.link_bw   = base + pff_pkg::metric_t'($urandom_range(7));
    end else if (mode >= 65 && mode < 85) begin
      t           = $urandom_range(63);
      p.compute   = base + pff_pkg::metric_t'(t);
      p.capacity  = base + pff_pkg::metric_t'(63 - t);
      p.memory_bw = base + pff_pkg::metric_t'($urandom_range(1));
      p.link_bw   = base + pff_pkg::metric_t'($urandom_range(1));
    end else begin
      p = {$urandom, $urandom, $urandom, $urandom};
    end
    recent_q = {recent_q, p};
    return make_cand(p.compute, p.capacity, p.memory_bw, p.link_bw, ends);
  endfunction

  task automatic run_batch(int len);
    pff_pkg::metric_t base;
    case ($urandom_range(2))
      0: base = '0;
      1: base = 32'h7fff_fff8;
      default: base = 32'hffff_fff0;
    endcase
    recent_q.delete();
    for (int i = 0; i < len; i++) send_cand(random_cand(base, i == len - 1));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_register_defaults();
    for (int i = 0; i < pff_pkg::NUM_REGS; i++) verify_floor(pff_pkg::reg_idx_t'(i));
  endtask

  // hand-picked points: extremes, ties, eviction, thresholds, empty front
  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    // all-ones point alone
    send_cand(make_cand('1, '1, '1, '1, 1'b1));
    // exact repeat replaces the older copy, zero point is a real entry
    send_cand(make_cand('0, '0, '0, '0, 1'b0));
    send_cand(make_cand('0, '0, '0, '0, 1'b1));
    // three incomparable points, then one that evicts all three
    send_cand(make_cand(1, 2, 3, 4, 1'b0));
    send_cand(make_cand(4, 3, 2, 1, 1'b0));
    send_cand(make_cand(2, 2, 2, 2, 1'b0));
    send_cand(make_cand(4, 3, 3, 4, 1'b0));
    // dominated point dropped, then an incomparable one lands in slot one
    send_cand(make_cand(0, 0, 0, 0, 1'b0));
    send_cand(make_cand(0, 0, 0, 32'hffff_ffff, 1'b1));
    // alternating bit patterns, incomparable pair
    send_cand(make_cand(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 1'b0));
    send_cand(make_cand(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 1'b1));
    wait_idle();
    set_floors(32'h100, 32'h200, 32'h300, 32'h400);
    // each metric one below its threshold: empty front at batch end
    send_cand(make_cand(32'hff, '1, '1, '1, 1'b0));
    send_cand(make_cand('1, 32'h1ff, '1, '1, 1'b0));
    send_cand(make_cand('1, '1, 32'h2ff, '1, 1'b0));
    send_cand(make_cand('1, '1, '1, 32'h3ff, 1'b1));
    // exactly at the thresholds passes, a failing batch end still dumps
    send_cand(make_cand(32'h100, 32'h200, 32'h300, 32'h400, 1'b0));
    send_cand(make_cand(0, 0, 0, 0, 1'b1));
    wait_idle();
    // top thresholds: only the all-ones point survives
    set_floors('1, '1, '1, '1);
    send_cand(make_cand(32'hffff_fffe, '1, '1, '1, 1'b0));
    send_cand(make_cand('1, '1, '1, '1, 1'b1));
    wait_idle();
  endtask

  // antichain fills all slots, the surplus sets the sticky flag, next batch clears it
  task automatic test_full_front();
    pff_pkg::cand_t   chain [$];
    pff_pkg::metric_t c;
    pff_pkg::metric_t k;
    idle_pct  = 27;
    stall_pct = 27;
    set_floors('0, '0, '0, '0);
    c = pff_pkg::metric_t'($urandom_range(32'h000f_ffff));
    k = 32'hf000_0000 + pff_pkg::metric_t'($urandom_range(16'hffff));
    // compute rising while capacity falls: no point covers another
    for (int i = 0; i < pff_pkg::FRONT_DEPTH + 4; i++) begin
      chain = {chain, make_cand(c, k, $urandom, $urandom, 1'b0)};
      c += pff_pkg::metric_t'($urandom_range(1, 4096));
      k -= pff_pkg::metric_t'($urandom_range(1, 4096));
    end
    // exactly full
    for (int i = 0; i < pff_pkg::FRONT_DEPTH; i++) begin
      chain[i].batch_end = (i == pff_pkg::FRONT_DEPTH - 1);
      send_cand(chain[i]);
      chain[i].batch_end = 1'b0;
    end
    // overfull, then a repeat that frees and refills one slot
    for (int i = 0; i < pff_pkg::FRONT_DEPTH + 4; i++) send_cand(chain[i]);
    chain[5].batch_end = 1'b1;
    send_cand(chain[5]);
    // flag gone in the next batch
    send_cand(make_cand(1, 1, 1, 1, 1'b1));
    wait_idle();
  endtask

  // random batches under each idling mix, fresh thresholds per mix
  task automatic test_random_phases();
    int idle_tab  [4] = '{0, 54, 0, 27};
    int stall_tab [4] = '{0, 0, 54, 27};
    int budget;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_tab[ph];
      stall_pct = stall_tab[ph];
      set_floors(rand_floor(), rand_floor(), rand_floor(), rand_floor());
      budget = 0;
      while (budget < 70) begin
        // mostly short batches, now and then a long one that can fill the front
        if ($urandom_range(9) == 0) begin
          run_batch($urandom_range(30, 45));
          budget += 38;
        end else begin
          run_batch($urandom_range(1, 20));
          budget += 10;
        end
      end
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_defaults();
    test_directed();
    test_full_front();
    test_random_phases();
    wait_idle();
    $display("covered %0d requests in %0d batches (%0d overflowed), %0d front entries",
             requests_sent, batches_done, overflow_batches, entries_seen);
    $display("%0d threshold writes, sender and receiver idling at 0, 27 and 54 percent",
             floor_writes);
    if (errors == 0) begin
      $display("pareto_front_filter_top: match");
    end else begin
      $display("pareto_front_filter_top: mismatch");
    end
    $finish;
  end

endmodule
